// File: hw/rtl/spfd_pkg.sv
// Package for the sparse pixel frame decoder: field widths, decode constants,
// queue sizing and the command type shared by front, queue, back and top.
// No dependencies.
package spfd_pkg;

    localparam int WORD_W    = 16;
    localparam int LEFT_W    = 17;
    localparam int NSTATE_W  = 4;
    localparam int ROW_W     = 11;
    localparam int COL_W     = 11;
    localparam int PIX_COL_W = 12;
    localparam int RUN_W     = 2;

    // Header word: row in [14:4], state count in [3:0].
    localparam int HDR_NS_LSB  = 0;
    localparam int HDR_ROW_LSB = 4;
    // State word: start column in [12:2], run length minus one in [1:0].
    localparam int ST_RUN_LSB  = 0;
    localparam int ST_COL_LSB  = 2;

    // Pivot position wraps at 9216 = 9 << 10; the offset is added first.
    localparam int PIVOT_OFFSET = 64;
    localparam int PIVOT_KB_SH  = 10;
    localparam int PIVOT_SPAN   = 9 << PIVOT_KB_SH;
    // floor(x / 9) for x <= 64 is (x * 57) >> 9.
    localparam int PIVOT_RECIP    = 57;
    localparam int PIVOT_RECIP_SH = 9;
    localparam int PIVOT_ROW_SH   = 4;

    // Command queue between front and back.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [RUN_W-1:0] run_m1;
        logic [ROW_W-1:0] row;
        logic             after_pivot;
        logic             frame;
    } t_hit_cmd;

endpackage

// File: hw/rtl/spfd_if.sv
// Handshake interfaces for the decoder: input half-word channel and pixel
// output channel. Depends on spfd_pkg.
interface spfd_word_if;
    logic                        valid;
    logic                        ready;
    logic [spfd_pkg::WORD_W-1:0] data_word;
    logic [spfd_pkg::LEFT_W-1:0] words_left;
    logic                        frame_index;
    logic [spfd_pkg::WORD_W-1:0] pivot_raw;

    modport source (output valid, data_word, words_left, frame_index, pivot_raw,
                    input ready);
    modport sink   (input valid, data_word, words_left, frame_index, pivot_raw,
                    output ready);
endinterface

interface spfd_pixel_if;
    logic                           valid;
    logic                           ready;
    logic [spfd_pkg::PIX_COL_W-1:0] pixel_column;
    logic [spfd_pkg::ROW_W-1:0]     pixel_row;
    logic                           after_pivot;
    logic                           hit_frame;
    logic                           last_of_run;

    modport source (output valid, pixel_column, pixel_row, after_pivot, hit_frame,
                    last_of_run, input ready);
    modport sink   (input valid, pixel_column, pixel_row, after_pivot, hit_frame,
                    last_of_run, output ready);
endinterface

// File: hw/rtl/spfd_front.sv
// Front end: accepts half-words, tracks line and frame state, and pushes one
// command per state word into the queue. Depends on spfd_pkg, spfd_if.
module spfd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    spfd_word_if.sink           i_word,
    output logic                o_push,
    output spfd_pkg::t_hit_cmd  o_cmd,
    input  logic                i_full
);

    logic                              r_expect, n_expect;
    logic [spfd_pkg::NSTATE_W-1:0]     r_states_left, n_states_left;
    logic [spfd_pkg::ROW_W-1:0]        r_line_row, n_line_row;
    logic                              r_line_ap, n_line_ap;
    logic                              r_dropping, n_dropping;

    logic                              accept;
    logic                              last_word;
    logic [spfd_pkg::NSTATE_W-1:0]     hdr_ns;
    logic [spfd_pkg::ROW_W-1:0]        hdr_row;
    logic                              too_short;

    // pivot row = ((raw + 64) mod 9216) / 16
    logic [spfd_pkg::LEFT_W-1:0]       piv_sum;
    logic [6:0]                        piv_kb;
    logic [11:0]                       piv_qprod;
    logic [2:0]                        piv_q;
    logic [spfd_pkg::LEFT_W-1:0]       piv_wrap;
    logic [spfd_pkg::LEFT_W-1:0]       piv_pos;
    logic [spfd_pkg::ROW_W-1:0]        piv_row;
    logic                              hdr_ap;

    assign i_word.ready = !i_full;
    assign accept       = i_word.valid && !i_full;
    assign last_word    = i_word.words_left <= spfd_pkg::LEFT_W'(1);

    assign hdr_ns  = i_word.data_word[spfd_pkg::HDR_NS_LSB +: spfd_pkg::NSTATE_W];
    assign hdr_row = i_word.data_word[spfd_pkg::HDR_ROW_LSB +: spfd_pkg::ROW_W];
    assign too_short = ({{(spfd_pkg::LEFT_W-spfd_pkg::NSTATE_W){1'b0}}, hdr_ns}
                        + spfd_pkg::LEFT_W'(1)) > i_word.words_left;

    assign piv_sum   = {1'b0, i_word.pivot_raw} + spfd_pkg::LEFT_W'(spfd_pkg::PIVOT_OFFSET);
    assign piv_kb    = piv_sum[spfd_pkg::LEFT_W-1:spfd_pkg::PIVOT_KB_SH];
    assign piv_qprod = 12'(piv_kb * 12'(spfd_pkg::PIVOT_RECIP));
    assign piv_q     = piv_qprod[spfd_pkg::PIVOT_RECIP_SH +: 3];
    assign piv_wrap  = spfd_pkg::LEFT_W'(piv_q * spfd_pkg::LEFT_W'(spfd_pkg::PIVOT_SPAN));
    assign piv_pos   = piv_sum - piv_wrap;
    assign piv_row   = piv_pos[spfd_pkg::PIVOT_ROW_SH +: spfd_pkg::ROW_W];
    assign hdr_ap    = hdr_row >= piv_row;

    always_comb begin
        n_expect      = r_expect;
        n_states_left = r_states_left;
        n_line_row    = r_line_row;
        n_line_ap     = r_line_ap;
        n_dropping    = r_dropping;
        if (accept) begin
            priority if (r_dropping) begin
                // rest of frame discarded
            end else if (r_expect) begin
                n_states_left = r_states_left - spfd_pkg::NSTATE_W'(1);
                if (r_states_left == spfd_pkg::NSTATE_W'(1)) begin
                    n_expect = 1'b0;
                end
            end else if (!last_word) begin
                if (too_short) begin
                    n_dropping = 1'b1;
                end else begin
                    n_line_row = hdr_row;
                    n_line_ap  = hdr_ap;
                    if (hdr_ns != '0) begin
                        n_expect      = 1'b1;
                        n_states_left = hdr_ns;
                    end
                end
            end
            if (last_word) begin
                n_dropping    = 1'b0;
                n_expect      = 1'b0;
                n_states_left = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect      <= 1'b0;
            r_states_left <= '0;
            r_line_row    <= '0;
            r_line_ap     <= 1'b0;
            r_dropping    <= 1'b0;
        end else begin
            r_expect      <= n_expect;
            r_states_left <= n_states_left;
            r_line_row    <= n_line_row;
            r_line_ap     <= n_line_ap;
            r_dropping    <= n_dropping;
        end
    end

    assign o_push            = accept && !r_dropping && r_expect;
    assign o_cmd.col         = i_word.data_word[spfd_pkg::ST_COL_LSB +: spfd_pkg::COL_W];
    assign o_cmd.run_m1      = i_word.data_word[spfd_pkg::ST_RUN_LSB +: spfd_pkg::RUN_W];
    assign o_cmd.row         = r_line_row;
    assign o_cmd.after_pivot = r_line_ap;
    assign o_cmd.frame       = i_word.frame_index;

endmodule

// File: hw/rtl/spfd_queue.sv
// Short command queue between front and back, register file with one write
// and one read port. Depends on spfd_pkg.
module spfd_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  spfd_pkg::t_hit_cmd  i_cmd,
    output logic                o_full,
    input  logic                i_pop,
    output spfd_pkg::t_hit_cmd  o_head,
    output logic                o_empty
);

    spfd_pkg::t_hit_cmd              r_mem [spfd_pkg::QDEPTH];
    logic [spfd_pkg::QPTR_W-1:0]     r_wptr, n_wptr;
    logic [spfd_pkg::QPTR_W-1:0]     r_rptr, n_rptr;
    logic [spfd_pkg::QCNT_W-1:0]     r_count, n_count;

    assign o_full  = r_count == spfd_pkg::QCNT_W'(spfd_pkg::QDEPTH);
    assign o_empty = r_count == '0;
    assign o_head  = r_mem[r_rptr];

    always_comb begin
        n_wptr  = i_push ? r_wptr + spfd_pkg::QPTR_W'(1) : r_wptr;
        n_rptr  = i_pop  ? r_rptr + spfd_pkg::QPTR_W'(1) : r_rptr;
        n_count = r_count;
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + spfd_pkg::QCNT_W'(1);
            2'b01:   n_count = r_count - spfd_pkg::QCNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("queue pop while empty");
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + spfd_pkg::QCNT_W'(1)))
        else $error("queue count did not follow push");

endmodule

// File: hw/rtl/spfd_back.sv
// Back end: expands each queued state-word command into 1..4 pixels, one per
// cycle unless the output stalls, into a registered output stage. Depends on spfd_pkg, spfd_if.
module spfd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_empty,
    input  spfd_pkg::t_hit_cmd  i_head,
    output logic                o_pop,
    spfd_pixel_if.source        o_pixel
);

    logic [spfd_pkg::RUN_W-1:0]      r_off, n_off;
    logic                            r_valid, n_valid;
    logic [spfd_pkg::PIX_COL_W-1:0]  r_col;
    logic [spfd_pkg::ROW_W-1:0]      r_row;
    logic                            r_ap;
    logic                            r_frame;
    logic                            r_last;

    logic                            slot_free;
    logic                            emit;
    logic                            run_end;

    assign slot_free = !r_valid || o_pixel.ready;
    assign emit      = slot_free && !i_empty;
    assign run_end   = r_off == i_head.run_m1;
    assign o_pop     = emit && run_end;

    always_comb begin
        n_off   = r_off;
        n_valid = r_valid;
        if (emit) begin
            n_off   = run_end ? '0 : r_off + spfd_pkg::RUN_W'(1);
            n_valid = 1'b1;
        end else if (o_pixel.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_off   <= n_off;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_col   <= {1'b0, i_head.col}
                       + {{(spfd_pkg::PIX_COL_W-spfd_pkg::RUN_W){1'b0}}, r_off};
            r_row   <= i_head.row;
            r_ap    <= i_head.after_pivot;
            r_frame <= i_head.frame;
            r_last  <= run_end;
        end
    end

    assign o_pixel.valid        = r_valid;
    assign o_pixel.pixel_column = r_col;
    assign o_pixel.pixel_row    = r_row;
    assign o_pixel.after_pivot  = r_ap;
    assign o_pixel.hit_frame    = r_frame;
    assign o_pixel.last_of_run  = r_last;

    a_off_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty |-> (r_off <= i_head.run_m1))
        else $error("run offset past run length");
    a_pop_marks_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (o_pixel.valid && o_pixel.last_of_run))
        else $error("popped command without last pixel");
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pixel.valid && !o_pixel.ready)
        |=> (o_pixel.valid && $stable(o_pixel.pixel_column)))
        else $error("output word changed while stalled");

endmodule

// File: hw/rtl/sparse_pixel_frame_decoder_unit.sv
// Top level of the sparse pixel frame decoder: front end, command queue and
// pixel expander. Depends on spfd_pkg, spfd_if, spfd_front, spfd_queue, spfd_back.
//
//  channel   dir  modport  payload
//  i_word    in   sink     data_word[15:0] words_left[16:0] frame_index pivot_raw[15:0]
//  o_pixel   out  source   pixel_column[11:0] pixel_row[10:0] after_pivot hit_frame
//                          last_of_run
//
// The front takes one half-word per cycle while the command queue has room;
// headers and dropped words end there. Each state word becomes a queue
// command that the back expands at one pixel per cycle while the output is
// not stalled, so the pixel output sets the sustained rate. A state word is
// written into the queue, then its pixels are registered in the output stage.
// Synchronous active-low reset clears line state, queue and output valid. An
// output stall backs up through the 4-entry queue to i_word.ready.
module sparse_pixel_frame_decoder_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    spfd_word_if.sink      i_word,
    spfd_pixel_if.source   o_pixel
);

    // front -> queue
    logic                push;
    spfd_pkg::t_hit_cmd  push_cmd;
    logic                q_full;
    // queue -> back
    logic                pop;
    spfd_pkg::t_hit_cmd  head_cmd;
    logic                q_empty;

    spfd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_word  (i_word),
        .o_push  (push),
        .o_cmd   (push_cmd),
        .i_full  (q_full)
    );

    spfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_empty (q_empty)
    );

    spfd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_head  (head_cmd),
        .o_pop   (pop),
        .o_pixel (o_pixel)
    );

endmodule

// File: verif/sparse_pixel_frame_decoder_unit_tb.sv
// Self-checking testbench for sparse_pixel_frame_decoder_unit: a table of directed
// half-words, then random zero-suppressed frames, checked against typed pixels or an
// in-bench line decoder. Depends on spfd_pkg, spfd_if and the decoder RTL.
module sparse_pixel_frame_decoder_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS = 480;
    localparam int IDLE_LIMIT   = 1000;  // cycles with no word moving on either side
    localparam int HOLD_CYCLES  = 300;   // long output stall to back up the queue
    localparam int HOLD_AT      = 100;   // pixel count at which the stall starts
    localparam int DRAIN_CYCLES = 16;
    localparam int N_DIR        = 21;
    localparam int EXP_DEPTH    = 4096;  // expected-pixel store, used as a ring

    // one expected or observed pixel
    typedef struct packed {
        logic [spfd_pkg::PIX_COL_W-1:0] col;
        logic [spfd_pkg::ROW_W-1:0]     row;
        logic                           after_pivot;
        logic                           frame;
        logic                           last;
    } t_pixel;

    // directed row; chk set means the pixels are typed in (n, col0, row, ap)
    typedef struct packed {
        logic [spfd_pkg::WORD_W-1:0]    w;
        logic [spfd_pkg::LEFT_W-1:0]    wl;
        logic                           fr;
        logic [spfd_pkg::WORD_W-1:0]    piv;
        logic                           chk;
        logic [2:0]                     n;
        logic [spfd_pkg::PIX_COL_W-1:0] col0;
        logic [spfd_pkg::ROW_W-1:0]     row;
        logic                           ap;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    spfd_word_if  word_ch ();
    spfd_pixel_if pix_ch ();

    sparse_pixel_frame_decoder_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_word  (word_ch),
        .o_pixel (pix_ch)
    );

    // line decoder state, mirrors the block
    logic                          ld_expect_states;
    logic [spfd_pkg::NSTATE_W-1:0] ld_states_left;
    logic [spfd_pkg::ROW_W-1:0]    ld_row;
    logic                          ld_after_pivot;
    logic                          ld_dropping;

    t_pixel   run_pix [4];
    t_pixel   exp_mem [EXP_DEPTH];
    t_dir_row dir_tbl [0:N_DIR-1];

    int  exp_wr;
    int  exp_rd;
    int  mismatches;
    int  idle_cycles;
    int  pix_count;
    int  words_sent;
    bit  tx_calm;
    bit  rx_calm;
    bit  hold_done;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // pixels expected and not yet seen
    function automatic int exp_level();
        return exp_wr - exp_rd;
    endfunction

    function automatic void add_expected(input t_pixel p);
        exp_mem[exp_wr % EXP_DEPTH] = p;
        exp_wr++;
    endfunction

    // pivot row: offset, wrap at the span, one row per 16 positions
    function automatic int pivot_line(input logic [spfd_pkg::WORD_W-1:0] raw);
        return ((spfd_pkg::PIVOT_SPAN + int'(raw) + spfd_pkg::PIVOT_OFFSET)
                % spfd_pkg::PIVOT_SPAN) >> spfd_pkg::PIVOT_ROW_SH;
    endfunction

    // Decode one half-word into run_pix[], return the pixel count.
    function automatic int decode_half_word(input logic [spfd_pkg::WORD_W-1:0] w,
                                            input logic [spfd_pkg::LEFT_W-1:0] wl,
                                            input logic fr,
                                            input logic [spfd_pkg::WORD_W-1:0] piv);
        bit                         last;
        int                         n;
        int                         ns;
        int                         run;
        logic [spfd_pkg::ROW_W-1:0] row;
        logic [spfd_pkg::COL_W-1:0] col;
        last = (wl <= 1);
        n    = 0;
        if (ld_dropping) begin
            // rest of the frame is discarded
        end else if (ld_expect_states) begin
            col = w[spfd_pkg::ST_COL_LSB +: spfd_pkg::COL_W];
            run = int'(w[spfd_pkg::ST_RUN_LSB +: spfd_pkg::RUN_W]) + 1;
            for (int j = 0; j < run; j++) begin
                run_pix[j].col         = spfd_pkg::PIX_COL_W'(col)
                                         + spfd_pkg::PIX_COL_W'(j);
                run_pix[j].row         = ld_row;
                run_pix[j].after_pivot = ld_after_pivot;
                run_pix[j].frame       = fr;
                run_pix[j].last        = (j == run - 1);
            end
            n = run;
            ld_states_left = ld_states_left - 1'b1;
            if (ld_states_left == 0)
                ld_expect_states = 1'b0;
        end else if (!last) begin
            ns  = int'(w[spfd_pkg::HDR_NS_LSB +: spfd_pkg::NSTATE_W]);
            row = w[spfd_pkg::HDR_ROW_LSB +: spfd_pkg::ROW_W];
            if (ns + 1 > int'(wl)) begin
                ld_dropping = 1'b1;
            end else begin
                ld_row         = row;
                ld_after_pivot = (int'(row) >= pivot_line(piv));
                if (ns > 0) begin
                    ld_expect_states = 1'b1;
                    ld_states_left   = spfd_pkg::NSTATE_W'(ns);
                end
            end
        end
        if (last) begin
            ld_dropping      = 1'b0;
            ld_expect_states = 1'b0;
            ld_states_left   = '0;
        end
        return n;
    endfunction

    // Offer one half-word, wait for it to be taken, then queue its pixels.
    // Called and returning at a rising edge.
    task automatic send_word(input logic [spfd_pkg::WORD_W-1:0] w,
                             input logic [spfd_pkg::LEFT_W-1:0] wl,
                             input logic fr, input logic [spfd_pkg::WORD_W-1:0] piv,
                             input logic chk, input int n_typed,
                             input logic [spfd_pkg::PIX_COL_W-1:0] col0,
                             input logic [spfd_pkg::ROW_W-1:0] row, input logic ap);
        int     gap;
        int     n;
        t_pixel px;
        if (words_sent % 24 == 0)
            tx_calm = ($urandom_range(0, 3) == 0);
        gap = tx_calm ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            word_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        word_ch.valid       <= 1'b1;
        word_ch.data_word   <= w;
        word_ch.words_left  <= wl;
        word_ch.frame_index <= fr;
        word_ch.pivot_raw   <= piv;
        // ready is looked at mid-cycle, away from the edge
        @(negedge i_clk);
        while (!word_ch.ready) begin
            @(posedge i_clk);
            @(negedge i_clk);
        end
        @(posedge i_clk);
        words_sent++;
        n = decode_half_word(w, wl, fr, piv);
        if (chk) begin
            // typed expectation takes the place of the decoder's pixels
            for (int j = 0; j < n_typed; j++) begin
                px.col         = col0 + spfd_pkg::PIX_COL_W'(j);
                px.row         = row;
                px.after_pivot = ap;
                px.frame       = fr;
                px.last        = (j == n_typed - 1);
                add_expected(px);
            end
        end else begin
            for (int j = 0; j < n; j++)
                add_expected(run_pix[j]);
        end
    endtask

    // One random frame: mostly well-formed lines, some noise words.
    task automatic send_random_frame();
        logic                          fr;
        logic [spfd_pkg::WORD_W-1:0]   piv;
        logic [spfd_pkg::WORD_W-1:0]   w;
        logic [spfd_pkg::LEFT_W-1:0]   wl;
        logic [spfd_pkg::ROW_W-1:0]    row;
        int                            len;
        int                            n_send;
        int                            due;
        int                            ns;
        int                            r;
        fr  = 1'($urandom_range(0, 1));
        piv = spfd_pkg::WORD_W'($urandom_range(0, 16'hffff));
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 131070)
                                          : $urandom_range(1, 40);
        n_send = (len < 30) ? len : $urandom_range(1, 30);
        due = 0;
        for (int k = 0; k < n_send; k++) begin
            // a long frame is cut short by jumping straight to the last word
            wl = (k == n_send - 1) ? spfd_pkg::LEFT_W'(1) : spfd_pkg::LEFT_W'(len - k);
            if ($urandom_range(0, 9) == 0) begin
                w = spfd_pkg::WORD_W'($urandom_range(0, 16'hffff));
            end else if (due > 0) begin
                w = spfd_pkg::WORD_W'($urandom_range(0, 16'hffff));
                due--;
            end else begin
                r = $urandom_range(0, 7);
                if (r == 0)
                    ns = $urandom_range(0, 15);   // may not fit: drop path
                else if (r == 1)
                    ns = 0;
                else
                    ns = $urandom_range(1, 4);
                row = ($urandom_range(0, 3) == 0)
                      ? spfd_pkg::ROW_W'($urandom_range(0, 600))
                      : spfd_pkg::ROW_W'($urandom_range(0, 2047));
                w = {1'($urandom_range(0, 1)), row, spfd_pkg::NSTATE_W'(ns)};
                due = ns;
            end
            send_word(w, wl, fr, piv, 1'b0, 0, '0, '0, 1'b0);
        end
    endtask

    // Watchdog: no word on either side for too long ends the run.
    always @(negedge i_clk) begin
        if ((word_ch.valid && word_ch.ready) || (pix_ch.valid && pix_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no word moved for %0d cycles, %0d pixels pending",
                     idle_cycles, exp_level());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Pixel sink: random ready gaps, one long stall, checks every pixel taken.
    initial begin : pixel_sink
        int     gap;
        t_pixel got;
        t_pixel want;
        pix_ch.ready = 1'b0;
        @(posedge i_rst_n);
        @(posedge i_clk);
        forever begin
            if (pix_count % 32 == 0)
                rx_calm = ($urandom_range(0, 3) == 0);
            gap = rx_calm ? 0 : $urandom_range(0, 5);
            if (!hold_done && pix_count >= HOLD_AT) begin
                // sender keeps offering while we stall: queue fills, input backs up
                hold_done = 1'b1;
                gap = HOLD_CYCLES;
            end
            if (gap > 0) begin
                pix_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pix_ch.ready <= 1'b1;
            @(negedge i_clk);
            while (!pix_ch.valid) begin
                @(posedge i_clk);
                @(negedge i_clk);
            end
            got.col         = pix_ch.pixel_column;
            got.row         = pix_ch.pixel_row;
            got.after_pivot = pix_ch.after_pivot;
            got.frame       = pix_ch.hit_frame;
            got.last        = pix_ch.last_of_run;
            @(posedge i_clk);
            pix_count++;
            if (exp_level() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pixel: col %0d row %0d ap %0b fr %0b last %0b",
                             got.col, got.row, got.after_pivot, got.frame, got.last);
            end else begin
                want = exp_mem[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"pixel %0d mismatch: exp col %0d row %0d ap %0b fr %0b ",
                                  "last %0b, got col %0d row %0d ap %0b fr %0b last %0b"},
                                 pix_count, want.col, want.row, want.after_pivot,
                                 want.frame, want.last, got.col, got.row,
                                 got.after_pivot, got.frame, got.last);
                end
            end
        end
    end

    initial begin : word_source
        t_dir_row d;
        exp_wr      = 0;
        exp_rd      = 0;
        mismatches  = 0;
        idle_cycles = 0;
        pix_count   = 0;
        words_sent  = 0;
        tx_calm     = 1'b0;
        rx_calm     = 1'b0;
        hold_done   = 1'b0;

        ld_expect_states = 1'b0;
        ld_states_left   = '0;
        ld_row           = '0;
        ld_after_pivot   = 1'b0;
        ld_dropping      = 1'b0;

        word_ch.valid       = 1'b0;
        word_ch.data_word   = '0;
        word_ch.words_left  = '0;
        word_ch.frame_index = 1'b0;
        word_ch.pivot_raw   = '0;
        i_rst_n             = 1'b0;

        //           word      left        fr    pivot     chk   n     col0     row      ap
        dir_tbl = '{
            // frame 0, pivot 0 -> pivot row 4
            '{16'h0000, 17'd10,     1'b0, 16'h0000, 1'b1, 3'd0, 12'd0,    11'd0,    1'b0}, // empty line
            '{16'h7ff2, 17'd9,      1'b0, 16'h0000, 1'b1, 3'd0, 12'd0,    11'd0,    1'b0}, // row 2047
            '{16'h0000, 17'd8,      1'b0, 16'h0000, 1'b1, 3'd1, 12'd0,    11'd2047, 1'b1}, // col 0
            '{16'h1fff, 17'd7,      1'b0, 16'h0000, 1'b1, 3'd4, 12'd2047, 11'd2047, 1'b1}, // top cols
            '{16'h0031, 17'd6,      1'b0, 16'h0000, 1'b1, 3'd0, 12'd0,    11'd0,    1'b0}, // row 3
            '{16'he005, 17'd5,      1'b0, 16'h0000, 1'b1, 3'd2, 12'd1,    11'd3,    1'b0}, // high bits
            '{16'h00ff, 17'd4,      1'b0, 16'h0000, 1'b1, 3'd0, 12'd0,    11'd0,    1'b0}, // too few
            '{16'h1fff, 17'd3,      1'b0, 16'h0000, 1'b1, 3'd0, 12'd0,    11'd0,    1'b0}, // dropped
            '{16'h1234, 17'd2,      1'b0, 16'h0000, 1'b1, 3'd0, 12'd0,    11'd0,    1'b0}, // dropped
            '{16'h0000, 17'd1,      1'b0, 16'h0000, 1'b1, 3'd0, 12'd0,    11'd0,    1'b0}, // end
            // frame 1, pivot ffff -> pivot row 67
            '{16'h0431, 17'd4,      1'b1, 16'hffff, 1'b1, 3'd0, 12'd0,    11'd0,    1'b0}, // row 67
            '{16'h0014, 17'd3,      1'b1, 16'hffff, 1'b1, 3'd1, 12'd5,    11'd67,   1'b1},
            '{16'h0421, 17'd2,      1'b1, 16'hffff, 1'b1, 3'd0, 12'd0,    11'd0,    1'b0}, // exact fit
            '{16'h0017, 17'd1,      1'b1, 16'hffff, 1'b1, 3'd4, 12'd5,    11'd66,   1'b0}, // last
            // header as last word, and zero left
            '{16'h0011, 17'd1,      1'b0, 16'h1234, 1'b1, 3'd0, 12'd0,    11'd0,    1'b0},
            '{16'h0021, 17'd0,      1'b0, 16'h1234, 1'b1, 3'd0, 12'd0,    11'd0,    1'b0},
            // longest frame count, decoder-checked
            '{16'h00a1, 17'd131070, 1'b1, 16'h8000, 1'b0, 3'd0, 12'd0,    11'd0,    1'b0},
            '{16'h2aaa, 17'd131069, 1'b1, 16'h8000, 1'b0, 3'd0, 12'd0,    11'd0,    1'b0},
            '{16'h0000, 17'd131068, 1'b1, 16'h8000, 1'b0, 3'd0, 12'd0,    11'd0,    1'b0},
            '{16'h800f, 17'd131067, 1'b1, 16'h8000, 1'b0, 3'd0, 12'd0,    11'd0,    1'b0},
            '{16'h5555, 17'd1,      1'b1, 16'h8000, 1'b0, 3'd0, 12'd0,    11'd0,    1'b0}  // cut line
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIR; i++) begin
            d = dir_tbl[i];
            send_word(d.w, d.wl, d.fr, d.piv, d.chk, int'(d.n), d.col0, d.row, d.ap);
        end

        while (words_sent < N_DIR + RANDOM_WORDS)
            send_random_frame();
        word_ch.valid <= 1'b0;

        // watchdog covers a block that never drains
        while (exp_level() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (exp_level() != 0) begin
            mismatches++;
            $display("%0d expected pixels never arrived", exp_level());
        end
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
